### sv/gsps_pkg.sv
package gsps_pkg;

  // Field widths
  localparam int unsigned PosW  = 8;
  localparam int unsigned GainW = 16;
  localparam int unsigned DutyW = 14;
  localparam int unsigned ErrW  = 9;
  localparam int unsigned DiffW = 10;
  localparam int unsigned PW    = GainW + ErrW;
  localparam int unsigned DW    = GainW + DiffW;
  localparam int unsigned IdxW  = 3;

  // Control law constants
  localparam logic [ErrW-1:0]  SETPOINT   = 9'd90;
  localparam logic [PosW-1:0]  TURN_LOW   = 8'd60;
  localparam logic [PosW-1:0]  TURN_HIGH  = 8'd120;
  localparam logic [19:0]      DUTY_SWING = 20'd90;
  localparam logic [19:0]      DUTY_MAX   = 20'd16383;

  // Register reset values
  localparam logic [GainW-1:0] TURN_GAIN_RST   = 16'd512;
  localparam logic [GainW-1:0] NORMAL_GAIN_RST = 16'd256;
  localparam logic [GainW-1:0] DERIV_GAIN_RST  = 16'd0;
  localparam logic [DutyW-1:0] CENTRE_DUTY_RST = 14'd760;
  localparam logic [DutyW-1:0] STOP_DUTY_RST   = 14'd785;

  // Register indexes
  typedef enum logic [IdxW-1:0] {
    REG_TURN_GAIN   = 3'd0,
    REG_NORMAL_GAIN = 3'd1,
    REG_DERIV_GAIN  = 3'd2,
    REG_CENTRE_DUTY = 3'd3,
    REG_STOP_DUTY   = 3'd4
  } reg_idx_e;

  typedef struct packed {
    logic signed [GainW-1:0] turn_gain;
    logic signed [GainW-1:0] normal_gain;
    logic signed [GainW-1:0] derivative_gain;
    logic        [DutyW-1:0] centre_duty;
    logic        [DutyW-1:0] stop_duty;
  } cfg_t;

  // Error stage payload
  typedef struct packed {
    logic signed [ErrW-1:0]  err;
    logic signed [DiffW-1:0] diff;
    logic signed [GainW-1:0] kp;
    logic                    stop;
  } err_t;

  // Product stage payload
  typedef struct packed {
    logic signed [PW-1:0] p_term;
    logic signed [DW-1:0] d_term;
    logic                 stop;
  } prod_t;

endpackage

### sv/gsps_err.sv
module gsps_err import gsps_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  cfg_t            cfg_i,
  input  logic            valid_i,
  output logic            ready_o,
  input  logic [PosW-1:0] pos_i,
  input  logic            stop_i,
  output logic            valid_o,
  input  logic            ready_i,
  output err_t            data_o
);

  logic                   valid_q, valid_d;
  logic signed [ErrW-1:0] prev_q, prev_d;
  err_t                   data_q, data_d;
  logic                   load;
  logic signed [ErrW-1:0] err;
  logic                   turn;

  assign ready_o = !valid_q || ready_i;
  assign load    = valid_i && ready_o;

  // Error, error change and gain select
  always_comb begin
    err  = signed'({1'b0, pos_i} - SETPOINT);
    turn = (pos_i < TURN_LOW) || (pos_i > TURN_HIGH);
    data_d.err  = err;
    data_d.diff = signed'({err[ErrW-1], err} - {prev_q[ErrW-1], prev_q});
    data_d.kp   = turn ? cfg_i.turn_gain : cfg_i.normal_gain;
    data_d.stop = stop_i;
    prev_d  = load ? err : prev_q;
    valid_d = ready_o ? valid_i : valid_q;
  end

  // Advance control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      prev_q  <= '0;
    end else begin
      valid_q <= valid_d;
      prev_q  <= prev_d;
    end
  end

  // Hold payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

### sv/gsps_mul.sv
module gsps_mul import gsps_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  cfg_t  cfg_i,
  input  logic  valid_i,
  output logic  ready_o,
  input  err_t  data_i,
  output logic  valid_o,
  input  logic  ready_i,
  output prod_t data_o
);

  logic  valid_q, valid_d;
  prod_t data_q, data_d;
  logic  load;

  assign ready_o = !valid_q || ready_i;
  assign load    = valid_i && ready_o;

  // Proportional and derivative products
  always_comb begin
    data_d.p_term = PW'(data_i.kp) * PW'(data_i.err);
    data_d.d_term = DW'(cfg_i.derivative_gain) * DW'(data_i.diff);
    data_d.stop   = data_i.stop;
    valid_d       = ready_o ? valid_i : valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

### sv/gsps_duty.sv
module gsps_duty import gsps_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cfg_t             cfg_i,
  input  logic             valid_i,
  output logic             ready_o,
  input  prod_t            data_i,
  output logic             valid_o,
  input  logic             ready_i,
  output logic [DutyW-1:0] duty_o,
  output logic             clamped_o
);

  logic               valid_q, valid_d;
  logic [DutyW-1:0]   duty_q, duty_d;
  logic               clamped_q, clamped_d;
  logic               load;
  logic signed [26:0] acc;
  logic signed [18:0] corr;
  logic signed [19:0] duty, lo, hi, centre;

  assign ready_o = !valid_q || ready_i;
  assign load    = valid_i && ready_o;

  // Sum, scale toward zero, offset and clamp
  always_comb begin
    acc    = {{2{data_i.p_term[PW-1]}}, data_i.p_term}
           + {data_i.d_term[DW-1], data_i.d_term};
    corr   = acc[26:8] + {18'd0, acc[26] && (acc[7:0] != 8'd0)};
    centre = signed'({6'd0, cfg_i.centre_duty});
    duty   = centre + {corr[18], corr};
    lo     = centre - signed'(DUTY_SWING);
    hi     = centre + signed'(DUTY_SWING);
    if (lo < 0) begin
      lo = '0;
    end
    if (hi > signed'(DUTY_MAX)) begin
      hi = signed'(DUTY_MAX);
    end
    clamped_d = 1'b0;
    if (duty < lo) begin
      duty      = lo;
      clamped_d = 1'b1;
    end else if (duty > hi) begin
      duty      = hi;
      clamped_d = 1'b1;
    end
    duty_d = duty[DutyW-1:0];
    // Stop overrides the loop output
    if (data_i.stop) begin
      duty_d    = cfg_i.stop_duty;
      clamped_d = 1'b0;
    end
    valid_d = ready_o ? valid_i : valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      duty_q    <= duty_d;
      clamped_q <= clamped_d;
    end
  end

  assign valid_o   = valid_q;
  assign duty_o    = duty_q;
  assign clamped_o = clamped_q;

endmodule

### sv/gain_scheduled_pd_servo_top.sv
// Channel | Signals                                              | Direction
// input   | in_valid_i, in_ready_o, line_position_i, stop_request_i | in
// output  | out_valid_o, out_ready_i, steer_duty_o, clamped_o       | out
// config  | cfg_we_i, cfg_idx_i, cfg_data_i                        | in
//
// One transaction per cycle sustained while the output is taken; a result passes
// through the error stage, multiplier stage and clamp/output register.
// Reset clears the stage valids, the previous error and loads register
// defaults. A stalled output backs up the three stages in turn; the input
// stays ready while any stage is free.
module gain_scheduled_pd_servo_top import gsps_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [IdxW-1:0]  cfg_idx_i,
  input  logic [GainW-1:0] cfg_data_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [PosW-1:0]  line_position_i,
  input  logic             stop_request_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [DutyW-1:0] steer_duty_o,
  output logic             clamped_o
);

  cfg_t  cfg_q, cfg_d;
  logic  err_valid, err_ready;
  err_t  err_data;
  logic  mul_valid, mul_ready;
  prod_t mul_data;

  // Register writes; unknown indexes drop
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_TURN_GAIN:   cfg_d.turn_gain       = signed'(cfg_data_i);
        REG_NORMAL_GAIN: cfg_d.normal_gain     = signed'(cfg_data_i);
        REG_DERIV_GAIN:  cfg_d.derivative_gain = signed'(cfg_data_i);
        REG_CENTRE_DUTY: cfg_d.centre_duty     = cfg_data_i[DutyW-1:0];
        REG_STOP_DUTY:   cfg_d.stop_duty       = cfg_data_i[DutyW-1:0];
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.turn_gain       <= signed'(TURN_GAIN_RST);
      cfg_q.normal_gain     <= signed'(NORMAL_GAIN_RST);
      cfg_q.derivative_gain <= signed'(DERIV_GAIN_RST);
      cfg_q.centre_duty     <= CENTRE_DUTY_RST;
      cfg_q.stop_duty       <= STOP_DUTY_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  gsps_err u_err (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .valid_i (in_valid_i),
    .ready_o (in_ready_o),
    .pos_i   (line_position_i),
    .stop_i  (stop_request_i),
    .valid_o (err_valid),
    .ready_i (err_ready),
    .data_o  (err_data)
  );

  gsps_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .valid_i (err_valid),
    .ready_o (err_ready),
    .data_i  (err_data),
    .valid_o (mul_valid),
    .ready_i (mul_ready),
    .data_o  (mul_data)
  );

  gsps_duty u_duty (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .valid_i   (mul_valid),
    .ready_o   (mul_ready),
    .data_i    (mul_data),
    .valid_o   (out_valid_o),
    .ready_i   (out_ready_i),
    .duty_o    (steer_duty_o),
    .clamped_o (clamped_o)
  );

endmodule

### sv/gsps_checker.sv
module gsps_checker import gsps_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_ready_o,
  input logic             out_valid_o,
  input logic             out_ready_i,
  input logic [DutyW-1:0] steer_duty_o,
  input logic             clamped_o
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(steer_duty_o)
      && $stable(clamped_o))
    else $error("stalled result changed or dropped");

  // Empty output means the whole pipe can drain, so input is ready
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled while output empty");

  // A fresh result comes from an input transaction through the error, multiplier and output registers
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o, 3))
    else $error("result without matching input transaction");

  // Result register empties only when taken
  a_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(out_valid_o) |-> $past(out_ready_i))
    else $error("result dropped without being taken");

endmodule

bind gain_scheduled_pd_servo_top gsps_checker u_gsps_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_ready_o   (in_ready_o),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .steer_duty_o (steer_duty_o),
  .clamped_o    (clamped_o)
);

### tb/gain_scheduled_pd_servo_top_tb.sv
module gain_scheduled_pd_servo_top_tb;
  import gsps_pkg::*;

  localparam int PipeDepth  = 3;
  localparam int StallLimit = 2000;
  localparam int IdlePct    = 38;
  localparam int HoldCycles = 300;
  localparam logic [IdxW-1:0] RegUnusedFirst = 3'd5;

  typedef struct packed {
    logic [DutyW-1:0] duty;
    logic             clamped;
  } steer_result_t;

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [IdxW-1:0]  cfg_idx_i;
  logic [GainW-1:0] cfg_data_i;
  logic             in_valid_i;
  logic             in_ready_o;
  logic [PosW-1:0]  line_position_i;
  logic             stop_request_i;
  logic             out_valid_o;
  logic             out_ready_i;
  logic [DutyW-1:0] steer_duty_o;
  logic             clamped_o;

  // Shadow copy of the controller registers and state
  logic signed [GainW-1:0] turn_gain;
  logic signed [GainW-1:0] normal_gain;
  logic signed [GainW-1:0] deriv_gain;
  logic        [DutyW-1:0] centre_duty;
  logic        [DutyW-1:0] stop_duty;
  longint                  prior_err;

  steer_result_t expected_duty_q[$];

  int error_count;
  int items_sent;
  int results_seen;
  int reg_writes;
  int clamp_hits;
  int stop_hits;
  int in_idle_pct;
  int out_idle_pct;
  int hold_len;
  int hold_left;
  int quiet_cycles;

  gain_scheduled_pd_servo_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .line_position_i(line_position_i),
    .stop_request_i (stop_request_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .steer_duty_o   (steer_duty_o),
    .clamped_o      (clamped_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Compute the steering duty for one position and advance the error history
  function automatic steer_result_t compute_steering(input logic [PosW-1:0] pos,
                                                     input logic stop);
    steer_result_t res;
    longint err, kp, acc, duty, lo, hi;
    err = longint'(pos) - longint'(SETPOINT);
    kp  = (pos < TURN_LOW || pos > TURN_HIGH) ? longint'(turn_gain) : longint'(normal_gain);
    acc = kp * err + longint'(deriv_gain) * (err - prior_err);
    // Signed division truncates toward zero
    duty = longint'(centre_duty) + acc / 256;
    lo   = longint'(centre_duty) - longint'(DUTY_SWING);
    hi   = longint'(centre_duty) + longint'(DUTY_SWING);
    if (lo < 0) lo = 0;
    if (hi > longint'(DUTY_MAX)) hi = longint'(DUTY_MAX);
    res.clamped = 1'b0;
    if (duty < lo) begin
      duty = lo;
      res.clamped = 1'b1;
    end else if (duty > hi) begin
      duty = hi;
      res.clamped = 1'b1;
    end
    prior_err = err;
    if (stop) begin
      res.duty    = stop_duty;
      res.clamped = 1'b0;
    end else begin
      res.duty = duty[DutyW-1:0];
    end
    return res;
  endfunction

  function automatic logic [GainW-1:0] pick_gain();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return GainW'($urandom_range(0, 2048) - 1024);
    if (r == 6) return GainW'($urandom_range(0, 255) - 128);
    return GainW'($urandom);
  endfunction

  function automatic logic [PosW-1:0] pick_position();
    int r;
    r = $urandom_range(0, 19);
    case (r)
      0: return PosW'($urandom_range(int'(TURN_LOW) - 3, int'(TURN_LOW) + 3));
      1: return PosW'($urandom_range(int'(TURN_HIGH) - 3, int'(TURN_HIGH) + 3));
      2: return PosW'($urandom_range(int'(SETPOINT) - 3, int'(SETPOINT) + 3));
      3: return ($urandom_range(0, 1) == 0) ? PosW'(0) : {PosW{1'b1}};
      default: return PosW'($urandom_range(0, 255));
    endcase
  endfunction

  // Offer one transaction, idling first at random; valid is lowered only when idling
  task automatic send_item(input logic [PosW-1:0] pos, input logic stop);
    bit idled;
    idled = 1'b0;
    while ($urandom_range(0, 99) < in_idle_pct) begin
      if (!idled) in_valid_i <= 1'b0;
      idled = 1'b1;
      @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    line_position_i <= pos;
    stop_request_i  <= stop;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    expected_duty_q.push_back(compute_steering(pos, stop));
    items_sent++;
  endtask

  // Drop valid, wait for all results, then let the pipeline settle
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (expected_duty_q.size() != 0) @(posedge clk_i);
    repeat (PipeDepth + 1) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [IdxW-1:0] idx, input logic [GainW-1:0] data);
    wait_drained();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_TURN_GAIN:   turn_gain   = data;
      REG_NORMAL_GAIN: normal_gain = data;
      REG_DERIV_GAIN:  deriv_gain  = data;
      REG_CENTRE_DUTY: centre_duty = data[DutyW-1:0];
      REG_STOP_DUTY:   stop_duty   = data[DutyW-1:0];
      default: ;
    endcase
    reg_writes++;
  endtask

  task automatic load_random_config();
    int r;
    logic [DutyW-1:0] centre;
    r = $urandom_range(0, 9);
    if (r == 0)      centre = DutyW'($urandom_range(0, int'(DUTY_SWING) - 1));
    else if (r == 1) centre = DutyW'($urandom_range(int'(DUTY_MAX) - 89, int'(DUTY_MAX)));
    else             centre = DutyW'($urandom_range(90, 9909));
    write_reg(REG_TURN_GAIN, pick_gain());
    write_reg(REG_NORMAL_GAIN, pick_gain());
    write_reg(REG_DERIV_GAIN, pick_gain());
    write_reg(REG_CENTRE_DUTY, {2'($urandom), centre});
    write_reg(REG_STOP_DUTY, GainW'($urandom));
  endtask

  task automatic send_random_items(input int count);
    for (int i = 0; i < count; i++) begin
      send_item(pick_position(), $urandom_range(0, 99) < 15);
    end
  endtask

  // Reset values, gain zones and the stop override
  task automatic test_reset_defaults();
    send_item(PosW'(90), 1'b0);
    send_item(PosW'(0), 1'b0);
    send_item(PosW'(59), 1'b0);
    send_item(PosW'(60), 1'b0);
    send_item(PosW'(120), 1'b0);
    send_item(PosW'(121), 1'b0);
    send_item(PosW'(255), 1'b0);
    send_item(PosW'(200), 1'b1);
  endtask

  // Register extremes, window edges, truncation toward zero, unused indexes
  task automatic test_register_extremes();
    write_reg(REG_DERIV_GAIN, GainW'(128));
    send_item(PosW'(100), 1'b0);
    send_item(PosW'(81), 1'b0);
    // Small negative products must truncate to zero, not round down
    write_reg(REG_NORMAL_GAIN, GainW'(1));
    write_reg(REG_DERIV_GAIN, GainW'(0));
    send_item(PosW'(89), 1'b0);
    write_reg(REG_TURN_GAIN, 16'h7FFF);
    write_reg(REG_NORMAL_GAIN, 16'h8000);
    write_reg(REG_DERIV_GAIN, 16'h8000);
    send_item(PosW'(0), 1'b0);
    send_item(PosW'(255), 1'b0);
    send_item(PosW'(90), 1'b0);
    // Window below zero, upper data bits set
    write_reg(REG_CENTRE_DUTY, 16'hC000);
    send_item(PosW'(0), 1'b0);
    send_item(PosW'(91), 1'b0);
    // Window past the duty maximum
    write_reg(REG_CENTRE_DUTY, 16'hFFFF);
    send_item(PosW'(255), 1'b0);
    send_item(PosW'(0), 1'b0);
    write_reg(REG_STOP_DUTY, 16'hFFFF);
    send_item(PosW'(10), 1'b1);
    write_reg(REG_STOP_DUTY, 16'h0000);
    send_item(PosW'(170), 1'b1);
    for (int i = RegUnusedFirst; i < 2 ** IdxW; i++) begin
      write_reg(IdxW'(i), GainW'($urandom));
    end
    send_item(PosW'(140), 1'b0);
    send_item(PosW'(30), 1'b1);
  endtask

  task automatic test_random_phases();
    for (int p = 0; p < 8; p++) begin
      load_random_config();
      send_random_items(130);
    end
  endtask

  task automatic test_full_rate();
    load_random_config();
    in_idle_pct  = 0;
    out_idle_pct = 0;
    send_random_items(200);
    in_idle_pct  = IdlePct;
    out_idle_pct = IdlePct;
  endtask

  // Hold the receiver off while the sender keeps offering until the input stalls
  task automatic test_backpressure();
    load_random_config();
    in_idle_pct = 0;
    hold_len    = HoldCycles;
    send_random_items(150);
    in_idle_pct = IdlePct;
  endtask

  // Drive the receiver ready, with random idling and long hold-offs
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (hold_len > 0) begin
        hold_left = hold_len;
        hold_len  = 0;
      end
      if (hold_left > 0) begin
        out_ready_i <= 1'b0;
        hold_left--;
      end else begin
        out_ready_i <= ($urandom_range(0, 99) >= out_idle_pct);
      end
    end
  end

  // Check each result transaction against the oldest expectation
  always @(posedge clk_i) begin
    steer_result_t exp_res;
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_seen++;
      if (expected_duty_q.size() == 0) begin
        error_count++;
        $display("%0t: unexpected result duty=%0d clamped=%0b", $time, steer_duty_o,
                 clamped_o);
      end else begin
        exp_res = expected_duty_q.pop_front();
        if (exp_res.clamped) clamp_hits++;
        if (steer_duty_o !== exp_res.duty) begin
          error_count++;
          $display("%0t: steer_duty mismatch expected %0d actual %0d", $time,
                   exp_res.duty, steer_duty_o);
        end
        if (clamped_o !== exp_res.clamped) begin
          error_count++;
          $display("%0t: clamped mismatch expected %0b actual %0b", $time,
                   exp_res.clamped, clamped_o);
        end
      end
    end
  end

  // Count stop items accepted by the block
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o && stop_request_i) stop_hits++;
  end

  // End the run when no transaction moves for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= StallLimit) begin
        $display("%0t: timeout, %0d results still expected", $time, expected_duty_q.size());
        $display("gain_scheduled_pd_servo_top_tb: done, errors");
        $finish;
      end
    end
  end

  initial begin
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = '0;
    cfg_data_i      = '0;
    in_valid_i      = 1'b0;
    line_position_i = '0;
    stop_request_i  = 1'b0;
    turn_gain       = TURN_GAIN_RST;
    normal_gain     = NORMAL_GAIN_RST;
    deriv_gain      = DERIV_GAIN_RST;
    centre_duty     = CENTRE_DUTY_RST;
    stop_duty       = STOP_DUTY_RST;
    prior_err       = 0;
    error_count     = 0;
    items_sent      = 0;
    results_seen    = 0;
    reg_writes      = 0;
    clamp_hits      = 0;
    stop_hits       = 0;
    in_idle_pct     = IdlePct;
    out_idle_pct    = IdlePct;
    hold_len        = 0;
    hold_left       = 0;
    quiet_cycles    = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_register_extremes();
    test_random_phases();
    test_full_rate();
    test_backpressure();

    wait_drained();
    repeat (2 * PipeDepth) @(posedge clk_i);
    if (expected_duty_q.size() != 0) begin
      error_count++;
      $display("%0t: %0d results never arrived", $time, expected_duty_q.size());
    end

    $display("Covered %0d steering updates over %0d register writes, %0d results checked",
             items_sent, reg_writes, results_seen);
    $display("Saturated duties: %0d, stop overrides: %0d, mismatches: %0d",
             clamp_hits, stop_hits, error_count);
    if (error_count == 0) begin
      $display("gain_scheduled_pd_servo_top_tb: done, clean");
    end else begin
      $display("gain_scheduled_pd_servo_top_tb: done, errors");
    end
    $finish;
  end

endmodule
